### rtl/core/skht_pkg.sv
// Package for the string key hash table: sizes, status codes, payload types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package skht_pkg;
    localparam int TABLE_SIZE = 8;
    localparam int KEY_BYTES  = 32;
    localparam int SLOT_W     = $clog2(TABLE_SIZE);
    localparam int KIDX_W     = $clog2(KEY_BYTES);
    localparam int LEN_W      = $clog2(KEY_BYTES + 2);
    localparam int CNT_W      = $clog2(TABLE_SIZE + 1);
    localparam int KMEM_W     = SLOT_W + KIDX_W;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_FOUND     = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_TOO_LONG  = 3'd5;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  key_byte;
        logic        key_last;
        logic [15:0] entry_value;
    } skht_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] found_value;
        logic [2:0]  slot_position;
        logic [3:0]  occupancy;
    } skht_out_t;

    typedef enum logic [2:0] {
        S_COLLECT,
        S_PROBE,
        S_CMP_ISSUE,
        S_CMP_CHECK,
        S_COPY,
        S_RESULT
    } skht_state_t;
endpackage
`default_nettype wire

### rtl/core/string_key_hash_table.sv
// Top level of the string key hash table: collector, probe sequencer, memories.
// Depends on skht_pkg.
`timescale 1ns / 1ps
`default_nettype none
//
//  channel  direction  struct       handshake
//  in       input      skht_in_t    in_valid / in_stall
//  out      output     skht_out_t   out_valid / out_stall
//
// Non-last bytes are stored in the incoming key memory and folded into the hash.
// A last byte starts a probe unless the key is too long: per slot visited, the
// slot's metadata is read, then each key byte is compared (issue, check) if the
// lengths match, and one more issue closes the compare. An insert copies the key
// into the slot key memory. The single-port slot key memory sets the rate.
// Reset clears slot valid bits, counters and hash; the key memories need none.
// The result waits in an output register; input is stalled until it leaves.
module string_key_hash_table
    import skht_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire skht_in_t  in_data,
    output logic           out_valid,
    input  wire logic      out_stall,
    output skht_out_t      out_data
);
    // memories
    logic [7:0]  slot_key_mem [TABLE_SIZE*KEY_BYTES];
    logic [7:0]  inc_key_mem  [KEY_BYTES];
    logic [LEN_W-1:0] slot_len_mem [TABLE_SIZE];
    logic [15:0] slot_val_mem [TABLE_SIZE];
    logic [TABLE_SIZE-1:0] slot_valid_reg, slot_valid_next;

    skht_state_t state_reg, state_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [31:0]       hash_reg, hash_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SLOT_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0]  visit_reg, visit_next;
    logic [LEN_W-1:0]  bidx_reg, bidx_next;
    logic              req_reg, req_next;
    logic [15:0]       val_reg, val_next;
    logic              out_valid_reg, out_valid_next;
    skht_out_t         out_reg, out_next;

    // memory ports
    logic              sk_we;
    logic [KMEM_W-1:0] sk_addr;
    logic [7:0]        sk_wdata, sk_rdata;
    logic              ik_we;
    logic [KIDX_W-1:0] ik_waddr, ik_raddr;
    logic [7:0]        ik_wdata, ik_rdata;
    logic              meta_we;
    logic [LEN_W-1:0]  len_rdata;
    logic [15:0]       val_rdata;

    always_ff @(posedge clk)
    begin
        if (sk_we)
        begin
            slot_key_mem[sk_addr] <= sk_wdata;
        end
        sk_rdata <= slot_key_mem[sk_addr];
        if (ik_we)
        begin
            inc_key_mem[ik_waddr] <= ik_wdata;
        end
        ik_rdata <= inc_key_mem[ik_raddr];
        if (meta_we)
        begin
            slot_len_mem[pos_reg] <= len_reg;
            slot_val_mem[pos_reg] <= val_reg;
        end
        len_rdata <= slot_len_mem[pos_reg];
        val_rdata <= slot_val_mem[pos_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_COLLECT;
            len_reg        <= '0;
            hash_reg       <= '0;
            count_reg      <= '0;
            slot_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            len_reg        <= len_next;
            hash_reg       <= hash_next;
            count_reg      <= count_next;
            slot_valid_reg <= slot_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        visit_reg <= visit_next;
        bidx_reg  <= bidx_next;
        req_reg   <= req_next;
        val_reg   <= val_next;
        out_reg   <= out_next;
    end

    logic [31:0] hash_upd;
    logic        accept;
    logic [LEN_W-1:0] len_upd;
    logic        matched_len;

    assign in_stall  = (state_reg != S_COLLECT) || out_valid_reg;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign hash_upd  = {24'd0, in_data.key_byte} + (hash_reg << 6) + (hash_reg << 16)
                       - hash_reg;
    assign len_upd   = (len_reg < LEN_W'(KEY_BYTES)) ? len_reg + 1'b1
                                                      : LEN_W'(KEY_BYTES + 1);
    assign matched_len = (len_rdata == len_reg);

    always_comb
    begin
        state_next      = state_reg;
        len_next        = len_reg;
        hash_next       = hash_reg;
        count_next      = count_reg;
        slot_valid_next = slot_valid_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_next        = out_reg;
        pos_next        = pos_reg;
        visit_next      = visit_reg;
        bidx_next       = bidx_reg;
        req_next        = req_reg;
        val_next        = val_reg;
        sk_we           = 1'b0;
        sk_addr         = {pos_reg, bidx_reg[KIDX_W-1:0]};
        sk_wdata        = ik_rdata;
        ik_we           = 1'b0;
        ik_waddr        = len_reg[KIDX_W-1:0];
        ik_wdata        = in_data.key_byte;
        ik_raddr        = bidx_reg[KIDX_W-1:0];
        meta_we         = 1'b0;

        unique case (state_reg)
            S_COLLECT:
            begin
                if (accept)
                begin
                    ik_we     = (len_reg < LEN_W'(KEY_BYTES));
                    len_next  = len_upd;
                    hash_next = hash_upd;
                    if (in_data.key_last)
                    begin
                        req_next   = in_data.req_type;
                        val_next   = in_data.entry_value;
                        pos_next   = hash_upd[SLOT_W-1:0];
                        visit_next = '0;
                        if (len_upd > LEN_W'(KEY_BYTES))
                        begin
                            out_next   = '{ST_TOO_LONG, 16'd0, 3'd0, 4'(count_reg)};
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            state_next = S_PROBE;
                        end
                    end
                end
            end
            S_PROBE:
            begin
                // metadata read for pos_reg issued this cycle
                if (visit_reg == CNT_W'(TABLE_SIZE))
                begin
                    out_next   = '{(req_reg ? ST_NOT_FOUND : ST_FULL), 16'd0, 3'd0,
                                   4'(count_reg)};
                    state_next = S_RESULT;
                end
                else if (!slot_valid_reg[pos_reg])
                begin
                    if (!req_reg)
                    begin
                        meta_we    = 1'b1;
                        slot_valid_next[pos_reg] = 1'b1;
                        count_next = count_reg + 1'b1;
                        out_next   = '{ST_INSERTED, 16'd0, 3'(pos_reg),
                                       4'(count_reg + 1'b1)};
                        bidx_next  = '0;
                        state_next = S_COPY;
                    end
                    else
                    begin
                        out_next   = '{ST_NOT_FOUND, 16'd0, 3'd0, 4'(count_reg)};
                        state_next = S_RESULT;
                    end
                end
                else
                begin
                    bidx_next  = '0;
                    ik_raddr   = '0;
                    state_next = S_CMP_ISSUE;
                end
            end
            S_CMP_ISSUE:
            begin
                // byte bidx read in flight; length/value data now valid
                if (!matched_len || bidx_reg == len_reg)
                begin
                    if (matched_len)
                    begin
                        out_next   = '{(req_reg ? ST_FOUND : ST_DUPLICATE),
                                       (req_reg ? val_rdata : 16'd0), 3'(pos_reg),
                                       4'(count_reg)};
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        pos_next   = pos_reg + 1'b1;
                        visit_next = visit_reg + 1'b1;
                        state_next = S_PROBE;
                    end
                end
                else
                begin
                    state_next = S_CMP_CHECK;
                end
            end
            S_CMP_CHECK:
            begin
                if (sk_rdata != ik_rdata)
                begin
                    pos_next   = pos_reg + 1'b1;
                    visit_next = visit_reg + 1'b1;
                    state_next = S_PROBE;
                end
                else
                begin
                    bidx_next  = bidx_reg + 1'b1;
                    sk_addr    = {pos_reg, KIDX_W'(bidx_reg + 1'b1)};
                    ik_raddr   = KIDX_W'(bidx_reg + 1'b1);
                    state_next = S_CMP_ISSUE;
                end
            end
            S_COPY:
            begin
                // ik byte bidx-1 valid; write it, read next
                if (bidx_reg != '0)
                begin
                    sk_we   = 1'b1;
                    sk_addr = {pos_reg, KIDX_W'(bidx_reg - 1'b1)};
                end
                ik_raddr = bidx_reg[KIDX_W-1:0];
                if (bidx_reg == len_reg)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    bidx_next = bidx_reg + 1'b1;
                end
            end
            S_RESULT:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    len_next       = '0;
                    hash_next      = '0;
                    state_next     = S_COLLECT;
                end
            end
            default:
            begin
                state_next = S_COLLECT;
            end
        endcase
    end
endmodule
`default_nettype wire
